[hw/rtl/oaht_pkg.sv]
// Shared types, constants and hash helpers for the open-addressing hash table.
// Used by the controller, datapath and top level.
`default_nettype none
package oaht_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = 11;
  localparam int unsigned LoadLimit = (Capacity * 7) / 8;
  localparam logic [7:0] TagEmpty = 8'h80;
  localparam logic [7:0] TagTomb = 8'hFE;
  localparam logic [63:0] Mul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] Mul2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    CmdPut = 2'd0,
    CmdGet = 2'd1,
    CmdRemove = 2'd2,
    CmdNop = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StMul1,
    StMul2,
    StHash,
    StRead,
    StWait,
    StCheck,
    StWrite,
    StOut
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture transaction
    logic mul_step;   // advance multiplier (one partial product)
    logic mul_first;  // start second multiply
    logic hash_mix;   // final mix stage
    logic check;      // evaluate probe result and step index
    logic wr;         // perform table update
    logic out_load;   // capture result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic mul_done;
    logic hit;
    logic empty;
    logic exhausted;
    logic need_wr;
  } sts_t;
endpackage
`default_nettype wire

[hw/rtl/oaht_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module oaht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/oaht_ctrl.sv]
// Controller state machine: hash, probe loop, update, result hand-off.
// Depends on oaht_pkg.
`default_nettype none
module oaht_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire logic           clr_done_i,
  input  oaht_pkg::sts_t      sts_i,
  output oaht_pkg::ctl_t      ctl_o
);
  oaht_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oaht_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_stall_o = (state_q != oaht_pkg::StIdle) || !clr_done_i;

  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      oaht_pkg::StIdle: begin
        if (in_valid_i && clr_done_i) begin
          ctl_o.load = 1'b1;
          state_d = oaht_pkg::StMul1;
        end
      end
      oaht_pkg::StMul1: begin
        ctl_o.mul_step = 1'b1;
        if (sts_i.mul_done) begin
          ctl_o.mul_first = 1'b1;
          state_d = oaht_pkg::StMul2;
        end
      end
      oaht_pkg::StMul2: begin
        ctl_o.mul_step = 1'b1;
        if (sts_i.mul_done) begin
          state_d = oaht_pkg::StHash;
        end
      end
      oaht_pkg::StHash: begin
        ctl_o.hash_mix = 1'b1;
        state_d = oaht_pkg::StRead;
      end
      oaht_pkg::StRead: begin
        state_d = oaht_pkg::StWait;
      end
      oaht_pkg::StWait: begin
        state_d = oaht_pkg::StCheck;
      end
      oaht_pkg::StCheck: begin
        ctl_o.check = 1'b1;
        if (sts_i.hit || sts_i.empty || sts_i.exhausted) begin
          state_d = sts_i.need_wr ? oaht_pkg::StWrite : oaht_pkg::StOut;
        end else begin
          state_d = oaht_pkg::StRead;
        end
      end
      oaht_pkg::StWrite: begin
        ctl_o.wr = 1'b1;
        state_d = oaht_pkg::StOut;
      end
      oaht_pkg::StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = oaht_pkg::StIdle;
        end
      end
      default: state_d = oaht_pkg::StIdle;
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/oaht_dp.sv]
// Datapath: splitmix hash with a shared 32x32 multiplier, probe index,
// slot memories, live count, tag clearing sweep. Depends on oaht_pkg, oaht_ram.
`default_nettype none
module oaht_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  oaht_pkg::ctl_t                   ctl_i,
  output oaht_pkg::sts_t                   sts_o,
  output logic                             clr_done_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic signed [63:0]          key_i,
  input  wire logic signed [63:0]          value_i,
  output logic                             found_o,
  output logic signed [63:0]               old_value_o,
  output logic [oaht_pkg::CntW-1:0]        entry_count_o,
  output logic                             status_o
);
  localparam int unsigned IdxW = oaht_pkg::IdxW;

  logic [1:0] cmd_q;
  logic [63:0] key_q, val_q, x_q, acc_q, mcand_q;
  logic [1:0] part_q;
  logic [IdxW-1:0] idx_q, step_q, tomb_q, wr_idx_q;
  logic tomb_v_q;
  logic [IdxW:0] n_q;
  logic [6:0] tag_q;
  logic [oaht_pkg::CntW-1:0] cnt_q;
  logic found_q, status_q;
  logic [63:0] old_q;
  logic [IdxW:0] clr_q;

  logic [7:0] tag_rd;
  logic [63:0] key_rd, val_rd;

  // multiplier: acc += a_part * b_part << shift, three partial products
  logic [63:0] mult_b_sel;
  logic second_q;
  logic [31:0] pa, pb;
  logic [63:0] prod;
  logic [63:0] pp;
  logic mul_done;
  assign mult_b_sel = second_q ? oaht_pkg::Mul2 : oaht_pkg::Mul1;
  always_comb begin
    pa = '0;
    pb = '0;
    pp = '0;
    case (part_q)
      2'd0: begin
        pa = mcand_q[31:0];
        pb = mult_b_sel[31:0];
      end
      2'd1: begin
        pa = mcand_q[63:32];
        pb = mult_b_sel[31:0];
      end
      default: begin
        pa = mcand_q[31:0];
        pb = mult_b_sel[63:32];
      end
    endcase
    prod = {32'h0, pa} * {32'h0, pb};
    pp = (part_q == 2'd0) ? prod : {prod[31:0], 32'h0};
  end
  assign mul_done = (part_q == 2'd2);

  logic [63:0] m1;
  assign m1 = (acc_q + pp) ^ ((acc_q + pp) >> 27);

  // probe evaluation
  logic is_empty, is_tomb, is_hit, last;
  assign is_empty = tag_rd == oaht_pkg::TagEmpty;
  assign is_tomb = tag_rd == oaht_pkg::TagTomb;
  assign is_hit = !is_empty && !is_tomb && (tag_rd[6:0] == tag_q) && tag_rd[7] == 1'b0
                  && (key_rd == key_q);
  assign last = (n_q == (IdxW + 1)'(oaht_pkg::Capacity - 1));

  // a tombstone in the final probed slot is still a usable spot
  logic [IdxW-1:0] spot;
  logic spot_v, full, put, rem, need_wr;
  assign spot_v = tomb_v_q || is_empty || is_tomb;
  assign spot = tomb_v_q ? tomb_q : idx_q;
  assign full = ({1'b0, cnt_q} + 12'd1) > 12'(oaht_pkg::LoadLimit);
  assign put = cmd_q == oaht_pkg::CmdPut;
  assign rem = cmd_q == oaht_pkg::CmdRemove;
  assign need_wr = (put && (is_hit || (spot_v && !full))) || (rem && is_hit);

  assign sts_o = '{mul_done: mul_done, hit: is_hit, empty: is_empty, exhausted: last,
                   need_wr: need_wr};

  // memory ports
  logic tag_we, kv_we, key_we;
  logic [IdxW-1:0] addr;
  logic [7:0] tag_wd;
  logic [63:0] val_wd;
  assign clr_done_o = clr_q[IdxW];
  always_comb begin
    tag_we = 1'b0;
    key_we = 1'b0;
    kv_we = 1'b0;
    addr = idx_q;
    tag_wd = oaht_pkg::TagEmpty;
    val_wd = val_q;
    if (!clr_done_o) begin
      tag_we = 1'b1;
      addr = clr_q[IdxW-1:0];
    end else if (ctl_i.wr) begin
      addr = wr_idx_q;
      if (rem) begin
        tag_we = 1'b1;
        tag_wd = oaht_pkg::TagTomb;
      end else if (found_q) begin
        kv_we = 1'b1;
      end else begin
        tag_we = 1'b1;
        tag_wd = {1'b0, tag_q};
        kv_we = 1'b1;
        key_we = 1'b1;
      end
    end
  end

  oaht_ram #(.Width(8), .Depth(oaht_pkg::Capacity)) u_tag (
    .clk_i(clk_i), .we_i(tag_we), .addr_i(addr), .wdata_i(tag_wd), .rdata_o(tag_rd));
  oaht_ram #(.Width(64), .Depth(oaht_pkg::Capacity)) u_key (
    .clk_i(clk_i), .we_i(key_we), .addr_i(addr), .wdata_i(key_q), .rdata_o(key_rd));
  oaht_ram #(.Width(64), .Depth(oaht_pkg::Capacity)) u_val (
    .clk_i(clk_i), .we_i(kv_we), .addr_i(addr), .wdata_i(val_wd), .rdata_o(val_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      clr_q <= '0;
      part_q <= '0;
      second_q <= 1'b0;
    end else begin
      if (!clr_done_o) begin
        clr_q <= clr_q + 1'b1;
      end
      if (ctl_i.load) begin
        part_q <= '0;
        second_q <= 1'b0;
      end else if (ctl_i.mul_step) begin
        part_q <= mul_done ? 2'd0 : part_q + 2'd1;
        if (ctl_i.mul_first) begin
          second_q <= 1'b1;
        end
      end
      if (ctl_i.wr && !found_q && put) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (ctl_i.wr && rem && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      key_q <= key_i;
      val_q <= value_i;
      mcand_q <= key_i ^ (key_i >> 30);
      acc_q <= '0;
    end
    if (ctl_i.mul_step) begin
      if (ctl_i.mul_first) begin
        mcand_q <= m1;
        acc_q <= '0;
      end else if (mul_done) begin
        x_q <= acc_q + pp;
      end else begin
        acc_q <= acc_q + pp;
      end
    end
    if (ctl_i.hash_mix) begin
      tag_q <= x_q[6:0] ^ x_q[37:31];
      idx_q <= x_q[IdxW+6:7] ^ x_q[IdxW+37:38];
      step_q <= '0;
      n_q <= '0;
      tomb_v_q <= 1'b0;
      found_q <= 1'b0;
      status_q <= 1'b0;
      old_q <= '0;
    end
    if (ctl_i.check) begin
      if (is_tomb && !tomb_v_q) begin
        tomb_v_q <= 1'b1;
        tomb_q <= idx_q;
      end
      idx_q <= idx_q + step_q + 1'b1;
      step_q <= step_q + 1'b1;
      n_q <= n_q + 1'b1;
      if (is_hit || is_empty || last) begin
        found_q <= is_hit && cmd_q != oaht_pkg::CmdNop;
        old_q <= (is_hit && cmd_q != oaht_pkg::CmdNop) ? val_rd : 64'h0;
        wr_idx_q <= is_hit ? idx_q : spot;
        status_q <= put && !is_hit && (full || !spot_v);
      end
    end
    if (ctl_i.out_load) begin
      found_o <= found_q;
      old_value_o <= old_q;
      entry_count_o <= cnt_q;
      status_o <= status_q;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/open_addressing_hash_table_top.sv]
// Top level of the open-addressing hash table: controller plus datapath.
// Depends on oaht_pkg, oaht_ctrl, oaht_dp.
//
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | cmd_i, key_i, value_i
// out     | out_valid_o | out_stall_i | found_o, old_value_o, entry_count_o, status_o
//
// Each transaction runs two 64-bit multiplies on the shared 32x32 multiplier
// (three partial products each), a final mix, then probes that each wait for
// the registered slot-memory read, and a table write when one is needed; a new
// transaction is taken only after the result has been loaded.
// After reset a tag clearing sweep sets every tag slot to empty before input is taken.
// The result register holds until the output is taken; input stalls while busy.
`default_nettype none
module open_addressing_hash_table_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         cmd_i,
  input  wire logic signed [63:0]                 key_i,
  input  wire logic signed [63:0]                 value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    found_o,
  output logic signed [63:0]                      old_value_o,
  output logic [oaht_pkg::CntW-1:0]               entry_count_o,
  output logic                                    status_o
);
  oaht_pkg::ctl_t ctl;
  oaht_pkg::sts_t sts;
  logic clr_done;

  oaht_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .clr_done_i(clr_done),
    .sts_i(sts), .ctl_o(ctl));

  oaht_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl), .sts_o(sts), .clr_done_o(clr_done),
    .cmd_i(cmd_i), .key_i(key_i), .value_i(value_i), .found_o(found_o),
    .old_value_o(old_value_o), .entry_count_o(entry_count_o), .status_o(status_o));
endmodule
`default_nettype wire

[bench/tb_open_addressing_hash_table_top.sv]
// Testbench for open_addressing_hash_table_top: put/get/remove traffic with random idling,
// every result checked against an in-bench model of the probing hash map.
// Depends on oaht_pkg and the RTL of the block only.
`default_nettype none
module tb_open_addressing_hash_table_top;
  localparam int unsigned WatchLimit = 40000;
  localparam int unsigned Cap = oaht_pkg::Capacity;
  localparam int unsigned CntW = oaht_pkg::CntW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = oaht_pkg::CmdNop;
  logic signed [63:0] key_i = '0;
  logic signed [63:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic found_o;
  logic signed [63:0] old_value_o;
  logic [CntW-1:0] entry_count_o;
  logic status_o;

  typedef struct packed {
    logic found;
    logic [63:0] old_value;
    logic [CntW-1:0] entry_count;
    logic status;
  } reply_t;

  logic [7:0] map_tag [Cap];
  logic [63:0] map_key [Cap];
  logic [63:0] map_val [Cap];
  int unsigned map_live;
  reply_t pending_replies[$];
  logic [63:0] key_pool[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_bad = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_full = 0;

  always #5 clk_i = ~clk_i;

  open_addressing_hash_table_top uut (.*);

  function automatic logic [63:0] mix_key(logic [63:0] x);
    x = x ^ (x >> 30);
    x = x * 64'hbf58476d1ce4e5b9;
    x = x ^ (x >> 27);
    x = x * 64'h94d049bb133111eb;
    x = x ^ (x >> 31);
    return x;
  endfunction

  function automatic reply_t apply_command(oaht_pkg::cmd_e op, logic [63:0] k,
                                           logic [63:0] v);
    reply_t r;
    logic [63:0] h;
    logic [7:0] tg;
    int unsigned idx, tomb, spot, hit;
    bit present, ended;
    r = '0;
    h = mix_key(k);
    tg = {1'b0, h[6:0]};
    idx = 32'((h >> 7) % 64'(Cap));
    tomb = Cap;
    spot = Cap;
    present = 0;
    ended = 0;
    hit = 0;
    if (op != oaht_pkg::CmdNop) begin
      for (int unsigned n = 0; n < Cap && !ended; n++) begin
        if (map_tag[idx] == oaht_pkg::TagEmpty) begin
          spot = (tomb < Cap) ? tomb : idx;
          ended = 1;
        end else if (map_tag[idx] == oaht_pkg::TagTomb) begin
          if (tomb >= Cap) tomb = idx;
        end else if (map_tag[idx] == tg && map_key[idx] == k) begin
          present = 1;
          hit = idx;
          ended = 1;
        end
        if (!ended) idx = (idx + n + 1) % Cap;
      end
      if (!ended) spot = tomb;
      if (present) begin
        r.found = 1'b1;
        r.old_value = map_val[hit];
      end
      if (op == oaht_pkg::CmdPut) begin
        if (present) begin
          map_val[hit] = v;
        end else if (map_live + 1 > oaht_pkg::LoadLimit || spot >= Cap) begin
          r.status = 1'b1;
        end else begin
          map_key[spot] = k;
          map_val[spot] = v;
          map_tag[spot] = tg;
          map_live++;
        end
      end else if (op == oaht_pkg::CmdRemove && present) begin
        map_tag[hit] = oaht_pkg::TagTomb;
        if (map_live > 0) map_live--;
      end
    end
    r.entry_count = map_live[CntW-1:0];
    return r;
  endfunction

  // one transaction; driven at falling edges, accepted at a rising edge
  task automatic send_command(oaht_pkg::cmd_e op, logic [63:0] k, logic [63:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= op;
    key_i <= k;
    value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    pending_replies.push_back(apply_command(op, k, v));
    if (op == oaht_pkg::CmdPut && !pending_replies[$].status) key_pool.push_back(k);
    if (pending_replies[$].status) n_full++;
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] any_key();
    if (key_pool.size() != 0 && $urandom_range(3) != 0)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    return $urandom_range(3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(300));
  endfunction

  function automatic logic [63:0] any_value();
    return {$urandom, $urandom};
  endfunction

  always @(negedge clk_i)
    out_stall_i <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("timeout with %0d results outstanding", pending_replies.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (pending_replies.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_replies.pop_front();
        if (found_o !== want.found || old_value_o !== want.old_value ||
            entry_count_o !== want.entry_count || status_o !== want.status) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch #%0d: exp f=%0b v=%h n=%0d s=%0b got f=%0b v=%h n=%0d s=%0b",
                     n_checked, want.found, want.old_value, want.entry_count, want.status,
                     found_o, old_value_o, entry_count_o, status_o);
        end
      end
    end
  end

  task automatic test_directed;
    send_command(oaht_pkg::CmdGet, 64'h0, 64'h0);
    send_command(oaht_pkg::CmdRemove, 64'h0, 64'h0);
    send_command(oaht_pkg::CmdPut, 64'h0, 64'h7fffffffffffffff);
    send_command(oaht_pkg::CmdPut, 64'h8000000000000000, 64'h8000000000000000);
    send_command(oaht_pkg::CmdPut, 64'h7fffffffffffffff, 64'hffffffffffffffff);
    send_command(oaht_pkg::CmdPut, 64'hffffffffffffffff, 64'h0);
    send_command(oaht_pkg::CmdGet, 64'h8000000000000000, 64'h1234);
    send_command(oaht_pkg::CmdPut, 64'h0, 64'h5555aaaa5555aaaa);
    send_command(oaht_pkg::CmdGet, 64'h0, 64'h0);
    send_command(oaht_pkg::CmdRemove, 64'h7fffffffffffffff, 64'h0);
    send_command(oaht_pkg::CmdGet, 64'h7fffffffffffffff, 64'h0);
    send_command(oaht_pkg::CmdRemove, 64'h7fffffffffffffff, 64'h0);
    send_command(oaht_pkg::CmdPut, 64'h7fffffffffffffff, 64'haaaa5555aaaa5555);
    send_command(oaht_pkg::CmdNop, 64'hffffffffffffffff, 64'hffffffffffffffff);
    send_command(oaht_pkg::CmdGet, 64'hffffffffffffffff, 64'h0);
    send_command(oaht_pkg::CmdRemove, 64'hffffffffffffffff, 64'h0);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) send_command(oaht_pkg::CmdPut, any_key(), any_value());
      else if (pick < 75) send_command(oaht_pkg::CmdGet, any_key(), any_value());
      else if (pick < 97) send_command(oaht_pkg::CmdRemove, any_key(), any_value());
      else send_command(oaht_pkg::CmdNop, any_key(), any_value());
    end
  endtask

  // fills to the load limit, tries puts beyond it, then churns to build tombstones
  task automatic test_fill_and_churn;
    int unsigned k;
    k = 1000;
    while (map_live < oaht_pkg::LoadLimit) begin
      send_command(oaht_pkg::CmdPut, 64'(k), any_value());
      k++;
    end
    repeat (4) send_command(oaht_pkg::CmdPut, {$urandom, $urandom}, any_value());
    send_command(oaht_pkg::CmdPut, 64'(1000), 64'h1);
    for (int i = 0; i < 90; i++) begin
      send_command(oaht_pkg::CmdRemove, 64'(1000 + 2 * i), 64'h0);
      send_command(oaht_pkg::CmdPut, 64'(5000 + i), any_value());
    end
    for (int i = 0; i < 40; i++) send_command(oaht_pkg::CmdGet, 64'(1000 + i), 64'h0);
  endtask

  initial begin
    for (int i = 0; i < Cap; i++) map_tag[i] = oaht_pkg::TagEmpty;
    map_live = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    drain();
    test_random(100);
    send_idle_pct = 49;
    test_random(100);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    test_random(100);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    test_random(80);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_fill_and_churn();
    drain();
    repeat (200) @(negedge clk_i);
    $display("covered %0d transactions (%0d checked, %0d rejected as full) under",
             n_sent, n_checked, n_full);
    $display("idle sender, stalling receiver, fill to the load limit and tombstone churn");
    if (n_bad == 0 && pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ram.sv
hw/rtl/oaht_ctrl.sv
hw/rtl/oaht_dp.sv
hw/rtl/open_addressing_hash_table_top.sv
bench/tb_open_addressing_hash_table_top.sv
